[rtl/fcp_pkg.sv]
// ----------------------------------------------------------------------------
// fcp_pkg
// Shared types and constants of the framed ascii command parser.
// ----------------------------------------------------------------------------
package fcp_pkg;

  localparam int BYTE_W          = 8;
  localparam int CMD_W           = 48;
  localparam int TEXT_CHARS      = CMD_W / BYTE_W;
  localparam int VALUE_W         = 16;
  localparam int SUM_W           = 32;
  localparam int DUTY_W          = 8;
  localparam int STATUS_W        = 3;
  localparam int CFG_IDX_W       = 1;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_FIELD_CHARS = 20;
  localparam int MAX_FIELDS      = 20;

  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h3C;  // '<'
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h3E;  // '>'
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [DUTY_W-1:0] DUTY_FULL = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFF_WORD = 1'b0,
    CFG_ON_WORD  = 1'b1
  } cfg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALUES_OK = 3'd0,
    ST_SUM_BAD   = 3'd1,
    ST_OFF       = 3'd2,
    ST_ON        = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_TOO_MANY  = 3'd5
  } status_t;

  // one classified byte on its way from the front to the back
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [3:0]        digit;
    logic              is_open;
    logic              is_comma;
    logic              is_close;
    logic              is_digit;
    logic              above_nine;
  } token_t;

endpackage

[rtl/fcp_if.sv]
// ----------------------------------------------------------------------------
// fcp channel interfaces
// Valid/ready channels for received bytes, frame results and register writes.
// ----------------------------------------------------------------------------
interface fcp_byte_if;
  logic                       valid;
  logic                       ready;
  logic [fcp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcp_result_if;
  logic                         valid;
  logic                         ready;
  logic [fcp_pkg::STATUS_W-1:0] frame_status;
  logic [fcp_pkg::DUTY_W-1:0]   duty_a;
  logic [fcp_pkg::DUTY_W-1:0]   duty_b;
  logic                         lamp_level;

  modport source (output valid, output frame_status, output duty_a, output duty_b,
                  output lamp_level, input ready);
  modport sink   (input valid, input frame_status, input duty_a, input duty_b,
                  input lamp_level, output ready);
endinterface

interface fcp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fcp_pkg::CFG_IDX_W-1:0] index;
  logic [fcp_pkg::CMD_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/fcp_front.sv]
// ----------------------------------------------------------------------------
// fcp_front
// Accepts received bytes and classifies them into tokens for the queue.
// ----------------------------------------------------------------------------
module fcp_front (
  fcp_byte_if.sink        rx,
  input  logic            queue_full,
  output logic            push,
  output fcp_pkg::token_t push_token
);
  import fcp_pkg::*;

  logic [BYTE_W-1:0] offset;

  assign rx.ready = !queue_full;
  assign push     = rx.valid && !queue_full;
  assign offset   = rx.rx_byte - CH_ZERO;

  always_comb begin
    push_token            = '0;
    push_token.data       = rx.rx_byte;
    push_token.digit      = offset[3:0];
    push_token.is_open    = (rx.rx_byte == CH_OPEN);
    push_token.is_comma   = (rx.rx_byte == CH_COMMA);
    push_token.is_close   = (rx.rx_byte == CH_CLOSE);
    push_token.is_digit   = (rx.rx_byte >= CH_ZERO) && (rx.rx_byte <= CH_NINE);
    push_token.above_nine = (rx.rx_byte > CH_NINE);
  end

endmodule

[rtl/fcp_queue.sv]
// ----------------------------------------------------------------------------
// fcp_queue
// Two-entry token queue between the classifying front and the frame back.
// ----------------------------------------------------------------------------
module fcp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fcp_pkg::token_t push_token,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output fcp_pkg::token_t head_token
);
  import fcp_pkg::*;

  token_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic [QUEUE_CNT_W-1:0] count_next;

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_token = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !(push && !pop))
    else $error("token pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("token popped from an empty queue");
`endif

endmodule

[rtl/fcp_back.sv]
// ----------------------------------------------------------------------------
// fcp_back
// Frame state, field conversion, checksum and command match, result register.
// ----------------------------------------------------------------------------
module fcp_back #(
  parameter int MAX_FIELD_CHARS = fcp_pkg::MAX_FIELD_CHARS,
  parameter int MAX_FIELDS      = fcp_pkg::MAX_FIELDS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  fcp_pkg::token_t head_token,
  output logic            pop,
  fcp_cfg_if.sink         cfg,
  fcp_result_if.source    res
);
  import fcp_pkg::*;

  localparam int LEN_W = $clog2(MAX_FIELD_CHARS + 1);
  localparam int CNT_W = $clog2(MAX_FIELDS + 1);

  logic [CMD_W-1:0]   off_word;
  logic [CMD_W-1:0]   on_word;

  logic               in_frame, in_frame_next;
  logic [LEN_W-1:0]   field_length, field_length_next;
  logic [VALUE_W-1:0] field_number, field_number_next;
  logic               digits_stopped, digits_stopped_next;
  logic [CMD_W-1:0]   field_text, field_text_next;
  logic [CNT_W-1:0]   field_count, field_count_next;
  logic [SUM_W-1:0]   running_sum, running_sum_next;
  logic               command_mode, command_mode_next;
  logic [VALUE_W-1:0] first_value, first_value_next;
  logic [VALUE_W-1:0] second_value, second_value_next;
  logic [DUTY_W-1:0]  duty_a, duty_a_next;
  logic [DUTY_W-1:0]  duty_b, duty_b_next;
  logic               lamp, lamp_next;
  logic               out_valid, out_valid_next;
  status_t            out_status, out_status_next;

  logic               slot_free;
  logic               closing;
  logic               cmd_now;
  logic [VALUE_W-1:0] first_final;
  logic [VALUE_W-1:0] second_final;
  logic               short_text;

  assign cfg.ready = 1'b1;

  assign slot_free = !out_valid || res.ready;
  assign closing   = in_frame && head_token.is_close;
  assign pop       = head_valid && (!closing || slot_free);

  // a byte above '9' opening a field turns the whole frame into a command
  assign cmd_now      = command_mode ||
                        ((field_length == '0) && head_token.above_nine);
  assign first_value_next  = (field_count == CNT_W'(0)) ? field_number : first_value;
  assign second_value_next = (field_count == CNT_W'(1)) ? field_number : second_value;
  assign first_final  = first_value_next;
  assign second_final = second_value_next;
  assign short_text   = (field_length <= LEN_W'(TEXT_CHARS));

  always_comb begin
    in_frame_next       = in_frame;
    field_length_next   = field_length;
    field_number_next   = field_number;
    digits_stopped_next = digits_stopped;
    field_text_next     = field_text;
    field_count_next    = field_count;
    running_sum_next    = running_sum;
    command_mode_next   = command_mode;
    duty_a_next         = duty_a;
    duty_b_next         = duty_b;
    lamp_next           = lamp;
    out_status_next     = out_status;
    out_valid_next      = out_valid && !res.ready;

    if (pop) begin
      if (!in_frame) begin
        if (head_token.is_open) begin
          in_frame_next = 1'b1;
        end
      end else if (head_token.is_comma) begin
        command_mode_next   = cmd_now;
        running_sum_next    = running_sum + SUM_W'(field_number);
        if (field_count < CNT_W'(MAX_FIELDS)) begin
          field_count_next = field_count + 1'b1;
        end
        field_length_next   = '0;
        field_number_next   = '0;
        digits_stopped_next = 1'b0;
        field_text_next     = '0;
      end else if (!head_token.is_close) begin
        command_mode_next = cmd_now;
        if (field_length < LEN_W'(MAX_FIELD_CHARS)) begin
          for (int i = 0; i < TEXT_CHARS; i++) begin
            if (field_length == LEN_W'(i)) begin
              field_text_next[i*BYTE_W +: BYTE_W] = head_token.data;
            end
          end
          if (!digits_stopped && head_token.is_digit) begin
            field_number_next = {field_number[VALUE_W-4:0], 3'b000}
                              + {field_number[VALUE_W-2:0], 1'b0}
                              + VALUE_W'(head_token.digit);
          end else begin
            digits_stopped_next = 1'b1;
          end
          field_length_next = field_length + 1'b1;
        end
      end else begin
        // end of frame: settle the result and clear the frame state
        if (field_count >= CNT_W'(MAX_FIELDS)) begin
          out_status_next = ST_TOO_MANY;
        end else if (cmd_now) begin
          if (short_text && field_text == off_word) begin
            lamp_next       = 1'b1;
            duty_a_next     = '0;
            duty_b_next     = '0;
            out_status_next = ST_OFF;
          end else if (short_text && field_text == on_word) begin
            lamp_next       = 1'b0;
            duty_a_next     = DUTY_FULL;
            duty_b_next     = DUTY_FULL;
            out_status_next = ST_ON;
          end else begin
            out_status_next = ST_UNKNOWN;
          end
        end else if (running_sum == SUM_W'(field_number)) begin
          duty_a_next     = first_final[DUTY_W-1:0];
          duty_b_next     = second_final[DUTY_W-1:0];
          out_status_next = ST_VALUES_OK;
        end else begin
          out_status_next = ST_SUM_BAD;
        end
        out_valid_next      = 1'b1;
        in_frame_next       = 1'b0;
        field_length_next   = '0;
        field_number_next   = '0;
        digits_stopped_next = 1'b0;
        field_text_next     = '0;
        field_count_next    = '0;
        running_sum_next    = '0;
        command_mode_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off_word       <= '0;
      on_word        <= '0;
      in_frame       <= 1'b0;
      field_length   <= '0;
      field_number   <= '0;
      digits_stopped <= 1'b0;
      field_text     <= '0;
      field_count    <= '0;
      running_sum    <= '0;
      command_mode   <= 1'b0;
      first_value    <= '0;
      second_value   <= '0;
      duty_a         <= '0;
      duty_b         <= '0;
      lamp           <= 1'b0;
      out_valid      <= 1'b0;
      out_status     <= ST_VALUES_OK;
    end else begin
      if (cfg.valid) begin
        unique case (cfg_index_t'(cfg.index))
          CFG_OFF_WORD: off_word <= cfg.data;
          CFG_ON_WORD:  on_word  <= cfg.data;
          default:      off_word <= off_word;
        endcase
      end
      in_frame       <= in_frame_next;
      field_length   <= field_length_next;
      field_number   <= field_number_next;
      digits_stopped <= digits_stopped_next;
      field_text     <= field_text_next;
      field_count    <= field_count_next;
      running_sum    <= running_sum_next;
      command_mode   <= command_mode_next;
      duty_a         <= duty_a_next;
      duty_b         <= duty_b_next;
      lamp           <= lamp_next;
      out_valid      <= out_valid_next;
      out_status     <= out_status_next;
      // first and second values live only inside a frame
      if (pop && in_frame && head_token.is_comma) begin
        first_value  <= first_value_next;
        second_value <= second_value_next;
      end else if (pop && !in_frame) begin
        first_value  <= '0;
        second_value <= '0;
      end
    end
  end

  assign res.valid        = out_valid;
  assign res.frame_status = out_status;
  assign res.duty_a       = duty_a;
  assign res.duty_b       = duty_b;
  assign res.lamp_level   = lamp;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    field_count <= CNT_W'(MAX_FIELDS))
    else $error("field count above its limit");
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    field_length <= LEN_W'(MAX_FIELD_CHARS))
    else $error("field length above its limit");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (field_count == '0 && running_sum == '0 && !command_mode))
    else $error("frame state left over outside a frame");
  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |=> (out_valid && $stable(out_status)))
    else $error("pending result dropped or changed");
`endif

endmodule

[rtl/framed_ascii_command_parser_unit.sv]
// ----------------------------------------------------------------------------
// framed_ascii_command_parser_unit
// Parses '<'...'>' framed ascii frames into duty and lamp settings.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while the queue has room,
// and gives one result per frame closed by '>'. A byte is classified as it is
// accepted and passes through a two-entry queue to the frame stage, which
// updates the field and frame state for one byte per cycle unless a closing
// byte waits; a closing byte's result is held in an output register until
// taken. Input stalls only when the queue fills behind a result that waits.
module framed_ascii_command_parser_unit #(
  parameter int MAX_FIELD_CHARS = fcp_pkg::MAX_FIELD_CHARS,
  parameter int MAX_FIELDS      = fcp_pkg::MAX_FIELDS
) (
  input  logic         clk,
  input  logic         rst,
  fcp_byte_if.sink     rx,
  fcp_cfg_if.sink      cfg,
  fcp_result_if.source frame_out
);
  import fcp_pkg::*;

  logic   push;
  token_t push_token;
  logic   queue_full;
  logic   pop;
  logic   head_valid;
  token_t head_token;

  fcp_front u_front (
    .rx         (rx),
    .queue_full (queue_full),
    .push       (push),
    .push_token (push_token)
  );

  fcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_token (head_token)
  );

  fcp_back #(
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS),
    .MAX_FIELDS      (MAX_FIELDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_token (head_token),
    .pop        (pop),
    .cfg        (cfg),
    .res        (frame_out)
  );

endmodule
